@@ hdl/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and request structures of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int DATA_W = 8;
    localparam int OP_W   = 3;
    localparam int FLD_W  = 10;
    localparam int OUT_W  = 10;
    localparam int ST_W   = 2;
    localparam int CMP_W  = ((PTR_W > FLD_W) ? PTR_W : FLD_W) + 1;
    localparam int SUM_W  = CMP_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SKIP   = 3'd3,
        OP_STAGE  = 3'd4,
        OP_COMMIT = 3'd5,
        OP_CLEAR  = 3'd6
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        STS_OK        = 2'd0,
        STS_NO_DATA   = 2'd1,
        STS_NO_SPACE  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [PTR_W-1:0] held;
    } t_ptr_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PTR_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             rd_sel;
        logic [OUT_W-1:0] used;
        logic [OUT_W-1:0] free;
        logic [OUT_W-1:0] wroom;
        logic [OUT_W-1:0] rroom;
    } t_op_result;

    // position plus n, wrapping once; n stays below DEPTH where it is used
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                  input logic [CMP_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(n);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

@@ hdl/brb_ram.sv @@
// ----------------------------------------------------------------------------
// brb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10,
    parameter int WORDS  = 1024
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/brb_ops.sv @@
// ----------------------------------------------------------------------------
// brb_ops
// Operation decode: checks room, forms the memory request, the next
// positions and the status and room counts of one request.
// ----------------------------------------------------------------------------
module brb_ops (
    input  logic [brb_pkg::OP_W-1:0]   i_opcode,
    input  logic [brb_pkg::DATA_W-1:0] i_write_data,
    input  logic [brb_pkg::FLD_W-1:0]  i_amount,
    input  logic [brb_pkg::FLD_W-1:0]  i_offset,
    input  brb_pkg::t_ptr_state        i_ptr,
    output brb_pkg::t_ptr_state        o_ptr,
    output brb_pkg::t_mem_req          o_mem,
    output brb_pkg::t_op_result        o_res
);
    import brb_pkg::*;

    logic [PTR_W-1:0] free_cnt;
    logic [PTR_W-1:0] n_free;
    logic [CMP_W-1:0] held_c;
    logic [CMP_W-1:0] free_c;
    logic [CMP_W-1:0] amount_c;
    logic [CMP_W-1:0] offset_c;
    logic [CMP_W-1:0] offset_p1;
    t_ptr_state       nxt;
    logic [ST_W-1:0]  status;
    logic             rd_sel;
    logic [PTR_W-1:0] wroom;
    logic [PTR_W-1:0] rroom;

    assign free_cnt  = PTR_W'(DEPTH - 1) - i_ptr.held;
    assign held_c    = CMP_W'(i_ptr.held);
    assign free_c    = CMP_W'(free_cnt);
    assign amount_c  = CMP_W'(i_amount);
    assign offset_c  = CMP_W'(i_offset);
    assign offset_p1 = offset_c + CMP_W'(1);

    always_comb begin
        nxt         = i_ptr;
        status      = STS_OK;
        rd_sel      = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.re    = 1'b0;
        o_mem.addr  = '0;
        o_mem.wdata = i_write_data;
        case (i_opcode)
            OP_PUSH: begin
                if (free_cnt == '0) begin
                    status = STS_NO_SPACE;
                end else begin
                    o_mem.we   = 1'b1;
                    o_mem.addr = wrap_add(i_ptr.tail, CMP_W'(1));
                    nxt.tail   = o_mem.addr;
                    nxt.held   = i_ptr.held + PTR_W'(1);
                end
            end
            OP_POP: begin
                if (i_ptr.held == '0) begin
                    status = STS_NO_DATA;
                end else begin
                    o_mem.re   = 1'b1;
                    rd_sel     = 1'b1;
                    o_mem.addr = wrap_add(i_ptr.head, CMP_W'(1));
                    nxt.head   = o_mem.addr;
                    nxt.held   = i_ptr.held - PTR_W'(1);
                end
            end
            OP_PEEK: begin
                if (offset_c >= held_c) begin
                    status = STS_NO_DATA;
                end else begin
                    o_mem.re   = 1'b1;
                    rd_sel     = 1'b1;
                    o_mem.addr = wrap_add(i_ptr.head, offset_p1);
                end
            end
            OP_SKIP: begin
                if (amount_c > held_c) begin
                    status = STS_NO_DATA;
                end else begin
                    nxt.head = wrap_add(i_ptr.head, amount_c);
                    nxt.held = i_ptr.held - PTR_W'(i_amount);
                end
            end
            OP_STAGE: begin
                if (offset_c >= free_c) begin
                    status = STS_NO_SPACE;
                end else begin
                    o_mem.we   = 1'b1;
                    o_mem.addr = wrap_add(i_ptr.tail, offset_p1);
                end
            end
            OP_COMMIT: begin
                if (amount_c > free_c) begin
                    status = STS_NO_SPACE;
                end else begin
                    nxt.tail = wrap_add(i_ptr.tail, amount_c);
                    nxt.held = i_ptr.held + PTR_W'(i_amount);
                end
            end
            OP_CLEAR: begin
                nxt = '0;
            end
            default: begin
                nxt = i_ptr;
            end
        endcase
    end

    assign n_free = PTR_W'(DEPTH - 1) - nxt.held;

    always_comb begin
        if (nxt.tail >= nxt.head) begin
            wroom = PTR_W'(DEPTH - 1) - nxt.tail;
            rroom = nxt.tail - nxt.head;
        end else begin
            wroom = nxt.head - nxt.tail - PTR_W'(1);
            rroom = PTR_W'(DEPTH - 1) - nxt.head;
        end
    end

    assign o_ptr        = nxt;
    assign o_res.status = status;
    assign o_res.rd_sel = rd_sel;
    assign o_res.used   = OUT_W'(nxt.held);
    assign o_res.free   = OUT_W'(n_free);
    assign o_res.wroom  = OUT_W'(wroom);
    assign o_res.rroom  = OUT_W'(rroom);

endmodule

@@ hdl/byte_ring_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_unit
// Circular byte FIFO with push, pop, peek, skip, staged write, commit and
// clear requests over a single-port byte RAM.
// ----------------------------------------------------------------------------
// For each request the accepting edge issues the RAM access and updates the
// positions; the result, with the byte read from the single-port RAM, then
// moves into the output register once that register is empty or being taken.
// A new request is taken while the previous result still waits at the output;
// the byte store needs no clearing pass after reset.
module byte_ring_buffer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [brb_pkg::OP_W-1:0]   i_opcode,
    input  logic [brb_pkg::DATA_W-1:0] i_write_data,
    input  logic [brb_pkg::FLD_W-1:0]  i_amount,
    input  logic [brb_pkg::FLD_W-1:0]  i_offset,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [brb_pkg::DATA_W-1:0] o_read_data,
    output logic [brb_pkg::ST_W-1:0]   o_status,
    output logic [brb_pkg::OUT_W-1:0]  o_used_bytes,
    output logic [brb_pkg::OUT_W-1:0]  o_free_bytes,
    output logic [brb_pkg::OUT_W-1:0]  o_contiguous_write_room,
    output logic [brb_pkg::OUT_W-1:0]  o_contiguous_read_room
);
    import brb_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_ptr_state        r_ptr;
    t_ptr_state        ptr_nxt;
    t_mem_req          mem_req;
    t_op_result        op_res;
    t_op_result        r_pend;
    logic              r_out_valid;
    logic              n_out_valid;
    t_op_result        r_out;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] ram_rdata;
    logic              accept;
    logic              load_out;

    brb_ops u_ops (
        .i_opcode     (i_opcode),
        .i_write_data (i_write_data),
        .i_amount     (i_amount),
        .i_offset     (i_offset),
        .i_ptr        (r_ptr),
        .o_ptr        (ptr_nxt),
        .o_mem        (mem_req),
        .o_res        (op_res)
    );

    brb_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (PTR_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we & accept),
        .i_re    (mem_req.re & accept),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept = i_valid & o_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_ptr <= ptr_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= op_res;
        end
        if (load_out) begin
            r_out      <= r_pend;
            r_out_data <= r_pend.rd_sel ? ram_rdata : '0;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_read_data             = r_out_data;
    assign o_status                = r_out.status;
    assign o_used_bytes            = r_out.used;
    assign o_free_bytes            = r_out.free;
    assign o_contiguous_write_room = r_out.wroom;
    assign o_contiguous_read_room  = r_out.rroom;

endmodule

@@ hdl/brb_checker.sv @@
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks of the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       o_ready,
    input  logic                       o_valid,
    input  logic                       i_ready,
    input  logic [brb_pkg::DATA_W-1:0] o_read_data,
    input  logic [brb_pkg::ST_W-1:0]   o_status,
    input  logic [brb_pkg::OUT_W-1:0]  o_used_bytes,
    input  logic [brb_pkg::OUT_W-1:0]  o_free_bytes
);
    import brb_pkg::*;

    logic [OUT_W-1:0] count_sum;

    assign count_sum = o_used_bytes + o_free_bytes;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_used_bytes))
        else $error("stalled result changed");

    // one request in flight at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while another in flight");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> count_sum == OUT_W'(DEPTH - 1))
        else $error("used and free counts disagree");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STS_OK) |-> o_read_data == '0)
        else $error("refused request returned data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STS_OK) || (o_status == STS_NO_DATA) ||
                    (o_status == STS_NO_SPACE))
        else $error("status code out of range");

endmodule

bind byte_ring_buffer_unit brb_checker u_brb_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring buffer. Directed requests cover the
// edges of every operation, followed by random traffic with idle gaps,
// back-pressure and drain pauses. Each result is checked against an in-bench
// prediction of the ring contents and positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import brb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int ITEM_TARGET = 1050;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [ST_W-1:0]   status;
        logic [OUT_W-1:0]  used;
        logic [OUT_W-1:0]  free;
        logic [OUT_W-1:0]  wroom;
        logic [OUT_W-1:0]  rroom;
    } t_ring_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [OP_W-1:0]   i_opcode;
    logic [DATA_W-1:0] i_write_data;
    logic [FLD_W-1:0]  i_amount;
    logic [FLD_W-1:0]  i_offset;
    logic              o_valid;
    logic              i_ready;
    logic [DATA_W-1:0] o_read_data;
    logic [ST_W-1:0]   o_status;
    logic [OUT_W-1:0]  o_used_bytes;
    logic [OUT_W-1:0]  o_free_bytes;
    logic [OUT_W-1:0]  o_contiguous_write_room;
    logic [OUT_W-1:0]  o_contiguous_read_room;

    // predicted ring state
    logic [DATA_W-1:0] ring_mem [DEPTH];
    bit                ring_filled [DEPTH];
    int                ring_head;
    int                ring_tail;
    int                ring_held;

    t_ring_result      expected_q[$];
    int                errors;
    int                items_sent;
    int                hold_off_cycles;
    bit                send_idle;
    bit                recv_idle;

    byte_ring_buffer_unit u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_opcode                (i_opcode),
        .i_write_data            (i_write_data),
        .i_amount                (i_amount),
        .i_offset                (i_offset),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_read_data             (o_read_data),
        .o_status                (o_status),
        .o_used_bytes            (o_used_bytes),
        .o_free_bytes            (o_free_bytes),
        .o_contiguous_write_room (o_contiguous_write_room),
        .o_contiguous_read_room  (o_contiguous_read_room)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_ring_result apply_request(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic [FLD_W-1:0] amount,
                                                   input logic [FLD_W-1:0] offset);
        t_ring_result res;
        int           room;
        int           slot;
        res = '0;
        res.status = STS_OK;
        room = DEPTH - 1 - ring_held;
        case (op)
            OP_PUSH: begin
                if (room < 1) begin
                    res.status = STS_NO_SPACE;
                end else begin
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_mem[ring_tail] = data;
                    ring_filled[ring_tail] = 1'b1;
                    ring_held++;
                end
            end
            OP_POP: begin
                if (ring_held < 1) begin
                    res.status = STS_NO_DATA;
                end else begin
                    ring_head = (ring_head + 1) % DEPTH;
                    res.rdata = ring_mem[ring_head];
                    ring_held--;
                end
            end
            OP_PEEK: begin
                if (int'(offset) >= ring_held) begin
                    res.status = STS_NO_DATA;
                end else begin
                    res.rdata = ring_mem[(ring_head + 1 + int'(offset)) % DEPTH];
                end
            end
            OP_SKIP: begin
                if (int'(amount) > ring_held) begin
                    res.status = STS_NO_DATA;
                end else begin
                    ring_head = (ring_head + int'(amount)) % DEPTH;
                    ring_held -= int'(amount);
                end
            end
            OP_STAGE: begin
                if (int'(offset) >= room) begin
                    res.status = STS_NO_SPACE;
                end else begin
                    slot = (ring_tail + 1 + int'(offset)) % DEPTH;
                    ring_mem[slot] = data;
                    ring_filled[slot] = 1'b1;
                end
            end
            OP_COMMIT: begin
                if (int'(amount) > room) begin
                    res.status = STS_NO_SPACE;
                end else begin
                    ring_tail = (ring_tail + int'(amount)) % DEPTH;
                    ring_held += int'(amount);
                end
            end
            OP_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                ring_held = 0;
            end
            default: begin
            end
        endcase
        res.used = OUT_W'(ring_held);
        res.free = OUT_W'(DEPTH - 1 - ring_held);
        if (ring_tail >= ring_head) begin
            res.wroom = OUT_W'(DEPTH - 1 - ring_tail);
            res.rroom = OUT_W'(ring_tail - ring_head);
        end else begin
            res.wroom = OUT_W'(ring_head - ring_tail - 1);
            res.rroom = OUT_W'(DEPTH - 1 - ring_head);
        end
        return res;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input int data,
                                input int amount, input int offset);
        int gap;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_write_data <= DATA_W'(data);
        i_amount     <= FLD_W'(amount);
        i_offset     <= FLD_W'(offset);
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(apply_request(op, DATA_W'(data), FLD_W'(amount),
                                           FLD_W'(offset)));
        items_sent++;
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_result;
        t_ring_result exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t result with no request outstanding: expected none actual %0d",
                     $time, o_status);
        end else begin
            exp_r = expected_q.pop_front();
            report_field("read_data", 16'(exp_r.rdata), 16'(o_read_data));
            report_field("status", 16'(exp_r.status), 16'(o_status));
            report_field("used_bytes", 16'(exp_r.used), 16'(o_used_bytes));
            report_field("free_bytes", 16'(exp_r.free), 16'(o_free_bytes));
            report_field("write_room", 16'(exp_r.wroom), 16'(o_contiguous_write_room));
            report_field("read_room", 16'(exp_r.rroom), 16'(o_contiguous_read_room));
        end
    endtask

    // one random request, or a staged burst with its commit; never reads an unwritten slot
    task automatic random_request;
        int pick;
        int room;
        int k;
        int i;
        int off;
        int amt;
        bit descending;
        pick = $urandom_range(0, 99);
        room = DEPTH - 1 - ring_held;
        if (pick < 30) begin
            send_request(OP_PUSH, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 1022));
        end else if (pick < 55) begin
            if (ring_held > 0 && !ring_filled[(ring_head + 1) % DEPTH]) begin
                send_request(OP_SKIP, $urandom_range(0, 255), 1, $urandom_range(0, 1022));
            end else begin
                send_request(OP_POP, $urandom_range(0, 255), $urandom_range(0, 1023),
                             $urandom_range(0, 1022));
            end
        end else if (pick < 65) begin
            if (ring_held > 0 && $urandom_range(0, 4) != 0) begin
                off = $urandom_range(0, ring_held - 1);
            end else begin
                off = $urandom_range(0, 1022);
            end
            if (off < ring_held && !ring_filled[(ring_head + 1 + off) % DEPTH]) begin
                if (ring_held <= 1022) begin
                    send_request(OP_PEEK, $urandom_range(0, 255), $urandom_range(0, 1023),
                                 ring_held);
                end else begin
                    send_request(OP_SKIP, $urandom_range(0, 255), 0, off);
                end
            end else begin
                send_request(OP_PEEK, $urandom_range(0, 255), $urandom_range(0, 1023), off);
            end
        end else if (pick < 73) begin
            amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, ring_held);
            send_request(OP_SKIP, $urandom_range(0, 255), amt, $urandom_range(0, 1022));
        end else if (pick < 86) begin
            k = $urandom_range(1, 8);
            if (k > room) begin
                k = room;
            end
            descending = 1'($urandom_range(0, 1));
            if (k == 0) begin
                send_request(OP_STAGE, $urandom_range(0, 255), $urandom_range(0, 1023), 0);
            end
            for (i = 0; i < k; i++) begin
                send_request(OP_STAGE, $urandom_range(0, 255), $urandom_range(0, 1023),
                             descending ? k - 1 - i : i);
            end
            send_request(OP_COMMIT, $urandom_range(0, 255), k, $urandom_range(0, 1022));
        end else if (pick < 93) begin
            amt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 16);
            send_request(OP_COMMIT, $urandom_range(0, 255), amt, $urandom_range(0, 1022));
        end else if (pick < 96) begin
            send_request(OP_STAGE, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 1022));
        end else if (pick < 99) begin
            send_request(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 1022));
        end else begin
            send_request(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1023),
                         $urandom_range(0, 1022));
        end
    endtask

    task automatic test_directed_edges;
        send_request(OP_POP, 'h00, 0, 0);
        send_request(OP_PEEK, 'h00, 0, 0);
        send_request(OP_SKIP, 'h00, 1, 0);
        send_request(OP_SKIP, 'h00, 0, 0);
        send_request(OP_COMMIT, 'h00, 0, 0);
        send_request(OP_PUSH, 'h00, 0, 0);
        send_request(OP_PUSH, 'hFF, 0, 0);
        send_request(OP_PEEK, 'h00, 0, 0);
        send_request(OP_PEEK, 'h00, 0, 1);
        send_request(OP_PEEK, 'h00, 0, 2);
        send_request(OP_POP, 'h00, 0, 0);
        send_request(OP_STAGE, 'hA5, 0, 0);
        send_request(OP_STAGE, 'h5A, 0, 1);
        send_request(OP_COMMIT, 'h00, 2, 0);
        send_request(OP_PEEK, 'h00, 0, 2);
        send_request(OP_SKIP, 'h00, 3, 0);
        send_request(OP_UNUSED, 'hFF, 1023, 1022);
        send_request(OP_SKIP, 'h00, 1023, 0);
        // full ring through a commit of unstaged bytes
        send_request(OP_COMMIT, 'h00, 1023, 0);
        send_request(OP_PUSH, 'h3C, 0, 0);
        send_request(OP_STAGE, 'h3C, 0, 0);
        send_request(OP_COMMIT, 'h00, 1, 0);
        send_request(OP_SKIP, 'h00, 1023, 0);
        send_request(OP_STAGE, 'hC3, 0, 1022);
        send_request(OP_CLEAR, 'hFF, 1023, 1022);
    endtask

    task automatic test_back_to_back;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (100) random_request();
    endtask

    task automatic test_backpressure;
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_off_cycles = 300;
        repeat (60) random_request();
        wait_drained();
    endtask

    task automatic test_random_traffic;
        int chunk_end;
        while (items_sent < ITEM_TARGET) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            chunk_end = items_sent + 150;
            while (items_sent < chunk_end && items_sent < ITEM_TARGET) begin
                random_request();
            end
            wait_drained();
        end
    endtask

    initial begin : result_sink
        int gap;
        i_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = recv_idle ? $urandom_range(0, 11) : 0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            check_result();
        end
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = OP_PUSH;
        i_write_data    = '0;
        i_amount        = '0;
        i_offset        = '0;
        ring_head       = 0;
        ring_tail       = 0;
        ring_held       = 0;
        errors          = 0;
        items_sent      = 0;
        hold_off_cycles = 0;
        send_idle       = 1'b1;
        recv_idle       = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        wait_drained();
        test_back_to_back();
        wait_drained();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
